// ===== rtl/lsaf_pkg.sv =====
// Shared types, constants and register codes for the LED strip animation frame block.
`timescale 1ns / 1ps

package lsaf_pkg;

   localparam int LEDS_PER_SIDE = 16;
   localparam int FRAME_LEDS    = 4 * LEDS_PER_SIDE;
   localparam int ADDR_W        = $clog2(FRAME_LEDS);
   localparam int LED_INDEX_W   = 6;
   localparam int TICK_W        = 32;
   localparam int PERIOD_W      = 16;
   localparam int GAIN_W        = 10;
   localparam int CHAN_W        = 8;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 16;

   localparam logic [1:0] MODE_NONE   = 2'd0;
   localparam logic [1:0] MODE_ROTATE = 2'd1;
   localparam logic [1:0] MODE_SHIFT  = 2'd2;
   localparam logic [1:0] MODE_GLOW   = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_ANIMATION_MODE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EFFECT_MODE     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLICKER_PERIOD  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RED_GAIN        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GREEN_GAIN      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLUE_GAIN       = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRIGHTNESS_GAIN = 3'd6;

   localparam logic [GAIN_W-1:0] GAIN_UNITY = 10'd256;

   typedef struct packed {
      logic [CHAN_W-1:0] base_red;
      logic [CHAN_W-1:0] base_green;
      logic [CHAN_W-1:0] base_blue;
   } req_type;

   typedef struct packed {
      logic [LED_INDEX_W-1:0] led_index;
      logic [CHAN_W-1:0]      led_red;
      logic [CHAN_W-1:0]      led_green;
      logic [CHAN_W-1:0]      led_blue;
      logic                   frame_last;
   } rsp_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } colour_type;

   typedef struct packed {
      logic [1:0]          animation_mode;
      logic                effect_mode;
      logic [PERIOD_W-1:0] flicker_period;
      logic [GAIN_W-1:0]   red_gain;
      logic [GAIN_W-1:0]   green_gain;
      logic [GAIN_W-1:0]   blue_gain;
      logic [GAIN_W-1:0]   brightness_gain;
   } cfg_type;

endpackage

// ===== rtl/lsaf_scale.sv =====
// Colour scaling pipeline: channel gain, brightness gain, rounding, clamp and flicker blanking.
`timescale 1ns / 1ps

module lsaf_scale (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  lsaf_pkg::req_type     req_data,
   input  lsaf_pkg::cfg_type     cfg,
   input  logic                  blank,
   output lsaf_pkg::colour_type  col,
   output logic                  col_valid,
   output logic                  busy
);

   localparam int M1_W  = lsaf_pkg::CHAN_W + lsaf_pkg::GAIN_W;
   localparam int M2_W  = M1_W + lsaf_pkg::GAIN_W;
   localparam int FRAC  = 2 * lsaf_pkg::CHAN_W;
   localparam int V_W   = M2_W + 1 - FRAC;

   logic              vld1_ff, vld2_ff, vld3_ff;
   logic [M1_W-1:0]   m1_ff [3];
   logic [M1_W-1:0]   m1_in [3];
   logic [M2_W-1:0]   m2_ff [3];
   logic [M2_W-1:0]   m2_in [3];
   logic [lsaf_pkg::CHAN_W-1:0] base [3];
   logic [lsaf_pkg::GAIN_W-1:0] gain [3];
   logic [lsaf_pkg::CHAN_W-1:0] sat [3];
   lsaf_pkg::colour_type        col_ff, col_in;

   assign base[0] = req_data.base_red;
   assign base[1] = req_data.base_green;
   assign base[2] = req_data.base_blue;
   assign gain[0] = cfg.red_gain;
   assign gain[1] = cfg.green_gain;
   assign gain[2] = cfg.blue_gain;

   always_comb begin
      logic [M2_W:0]  sum;
      logic [V_W-1:0] v;
      for (int c = 0; c < 3; c++) begin
         m1_in[c] = M1_W'(base[c]) * M1_W'(gain[c]);
         m2_in[c] = M2_W'(m1_ff[c]) * M2_W'(cfg.brightness_gain);
         sum      = {1'b0, m2_ff[c]} + (M2_W+1)'(1 << (FRAC - 1));
         v        = sum[M2_W:FRAC];
         sat[c]   = (|v[V_W-1:lsaf_pkg::CHAN_W]) ? {lsaf_pkg::CHAN_W{1'b1}}
                                                 : v[lsaf_pkg::CHAN_W-1:0];
      end
      col_in.red   = blank ? '0 : sat[0];
      col_in.green = blank ? '0 : sat[1];
      col_in.blue  = blank ? '0 : sat[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else begin
         vld1_ff <= start;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         m1_ff <= m1_in;
      end
      if (vld1_ff) begin
         m2_ff <= m2_in;
      end
      if (vld2_ff) begin
         col_ff <= col_in;
      end
   end

   assign col       = col_ff;
   assign col_valid = vld3_ff;
   assign busy      = vld1_ff | vld2_ff | vld3_ff;

endmodule

// ===== rtl/lsaf_phase.sv =====
// Tick counter with flicker phase tracking and a bit-serial remainder unit for period changes.
`timescale 1ns / 1ps

module lsaf_phase (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              period_wr,
   input  lsaf_pkg::cfg_type cfg,
   output logic              blank,
   output logic              busy
);

   localparam int STEPS = lsaf_pkg::TICK_W;
   localparam int CNT_W = $clog2(STEPS + 1);
   localparam int SEL_W = $clog2(STEPS);
   localparam int P_W   = lsaf_pkg::PERIOD_W;

   logic [lsaf_pkg::TICK_W-1:0] tick_ff, tick_in;
   logic [P_W-1:0]              phase_ff, phase_in;
   logic [P_W:0]                phase_inc;
   logic [P_W:0]                rem_ff, rem_in, rem_shift;
   logic [CNT_W-1:0]            cnt_ff;
   logic [SEL_W-1:0]            bit_sel;
   logic                        blank_ff, blank_in;

   always_comb begin
      tick_in   = tick_ff + lsaf_pkg::TICK_W'(1);
      phase_inc = {1'b0, phase_ff} + (P_W+1)'(1);
      phase_in  = (tick_in == '0 || phase_inc == {1'b0, cfg.flicker_period})
                  ? '0 : phase_inc[P_W-1:0];
      blank_in  = cfg.effect_mode && (cfg.flicker_period != '0)
                  && (phase_in < (cfg.flicker_period >> 1));
      bit_sel   = SEL_W'(cnt_ff - CNT_W'(1));
      rem_shift = {rem_ff[P_W-1:0], tick_ff[bit_sel]};
      rem_in    = (rem_shift >= {1'b0, cfg.flicker_period})
                  ? rem_shift - {1'b0, cfg.flicker_period} : rem_shift;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff  <= '0;
         phase_ff <= '0;
         cnt_ff   <= '0;
         blank_ff <= 1'b0;
      end else if (period_wr) begin
         cnt_ff <= CNT_W'(STEPS);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            phase_ff <= rem_in[P_W-1:0];
         end
      end else if (accept) begin
         tick_ff  <= tick_in;
         phase_ff <= phase_in;
         blank_ff <= blank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (period_wr) begin
         rem_ff <= '0;
      end else if (cnt_ff != '0) begin
         rem_ff <= rem_in;
      end
   end

   assign blank = blank_ff;
   assign busy  = (cnt_ff != '0);

endmodule

// ===== rtl/lsaf_store.sv =====
// Frame memory with read-modify-write sweep and the result output register.
`timescale 1ns / 1ps

module lsaf_store (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  lsaf_pkg::colour_type col,
   input  logic [1:0]           mode,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lsaf_pkg::rsp_type    rsp_data,
   output logic                 busy
);

   localparam int AW = lsaf_pkg::ADDR_W;
   localparam logic [AW-1:0] LAST = AW'(lsaf_pkg::FRAME_LEDS - 1);

   lsaf_pkg::colour_type mem [lsaf_pkg::FRAME_LEDS];
   logic [lsaf_pkg::FRAME_LEDS-1:0] vld_ff;

   logic                 active_ff;
   logic [AW-1:0]        k_ff;
   logic [AW-1:0]        ptr_ff, ptr_in;
   logic [AW-1:0]        tgt_ff;
   logic                 s1_vld_ff;
   logic [AW-1:0]        s1_k_ff;
   lsaf_pkg::colour_type q_ff;
   logic                 q_vld_ff;
   logic                 rsp_valid_ff;
   lsaf_pkg::rsp_type    rsp_data_ff;

   logic                 out_free, s1_go, issue, wr_en;
   logic [AW-1:0]        rd_addr;
   lsaf_pkg::colour_type old_col, new_col;

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      s1_go    = s1_vld_ff && out_free;
      issue    = active_ff && (!s1_vld_ff || s1_go);
      rd_addr  = (mode == lsaf_pkg::MODE_SHIFT) ? k_ff + AW'(1) : k_ff;
      ptr_in   = (ptr_ff == '0) ? LAST : ptr_ff - AW'(1);
      old_col  = q_vld_ff ? q_ff : '0;
      unique case (mode)
         lsaf_pkg::MODE_ROTATE: new_col = (s1_k_ff == tgt_ff) ? col : old_col;
         lsaf_pkg::MODE_SHIFT:  new_col = (s1_k_ff == LAST) ? col : old_col;
         lsaf_pkg::MODE_GLOW:   new_col = col;
         default:               new_col = old_col;
      endcase
      wr_en = s1_go && (mode != lsaf_pkg::MODE_NONE);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[s1_k_ff] <= new_col;
      end
      if (issue) begin
         q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         active_ff    <= 1'b0;
         k_ff         <= '0;
         ptr_ff       <= '0;
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (start) begin
            active_ff <= 1'b1;
            k_ff      <= '0;
            if (mode == lsaf_pkg::MODE_ROTATE) begin
               ptr_ff <= ptr_in;
            end
         end else if (issue) begin
            k_ff <= k_ff + AW'(1);
            if (k_ff == LAST) begin
               active_ff <= 1'b0;
            end
         end
         if (issue) begin
            s1_vld_ff <= 1'b1;
         end else if (s1_go) begin
            s1_vld_ff <= 1'b0;
         end
         if (wr_en) begin
            vld_ff[s1_k_ff] <= 1'b1;
         end
         if (s1_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         tgt_ff <= ptr_ff;
      end
      if (issue) begin
         s1_k_ff  <= k_ff;
         q_vld_ff <= vld_ff[rd_addr];
      end
      if (s1_go) begin
         rsp_data_ff.led_index  <= lsaf_pkg::LED_INDEX_W'(s1_k_ff);
         rsp_data_ff.led_red    <= new_col.red;
         rsp_data_ff.led_green  <= new_col.green;
         rsp_data_ff.led_blue   <= new_col.blue;
         rsp_data_ff.frame_last <= (s1_k_ff == LAST);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign busy      = active_ff | s1_vld_ff;

endmodule

// ===== rtl/led_strip_animation_frame_top.sv =====
// Top level of the LED strip animation frame generator.
//
//   port group | direction | handshake           | payload
//   req_       | in        | req_valid/req_stall | req_data (base colour)
//   rsp_       | out       | rsp_valid/rsp_stall | rsp_data (one LED per item)
//   csr_       | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One input item yields 64 result items, one per cycle when rsp_stall stays low.
// An item passes 3 scaling stages, then a 64-step sweep through the frame memory, one
// read-modify-write per cycle while rsp_stall is low, on its single read and write port.
// A flicker_period write starts a bit-serial remainder pass; req_stall holds meanwhile.
// Reset is synchronous; the frame clears at once through per-entry valid bits.
// rsp_stall only pauses the sweep; no item is lost or repeated.
`timescale 1ns / 1ps

module led_strip_animation_frame_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  lsaf_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output lsaf_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lsaf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lsaf_pkg::CSR_DATA_W-1:0]     csr_data
);

   lsaf_pkg::cfg_type    cfg_ff;
   lsaf_pkg::colour_type col;
   logic                 accept, csr_wr, period_wr;
   logic                 blank, col_valid;
   logic                 scale_busy, phase_busy, store_busy;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign period_wr = csr_wr && (csr_index == lsaf_pkg::CSR_FLICKER_PERIOD);
   assign req_stall = scale_busy | phase_busy | store_busy;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.animation_mode  <= lsaf_pkg::MODE_GLOW;
         cfg_ff.effect_mode     <= 1'b1;
         cfg_ff.flicker_period  <= lsaf_pkg::PERIOD_W'(1);
         cfg_ff.red_gain        <= lsaf_pkg::GAIN_UNITY;
         cfg_ff.green_gain      <= lsaf_pkg::GAIN_UNITY;
         cfg_ff.blue_gain       <= lsaf_pkg::GAIN_UNITY;
         cfg_ff.brightness_gain <= lsaf_pkg::GAIN_UNITY;
      end else if (csr_wr) begin
         unique case (csr_index)
            lsaf_pkg::CSR_ANIMATION_MODE:  cfg_ff.animation_mode  <= csr_data[1:0];
            lsaf_pkg::CSR_EFFECT_MODE:     cfg_ff.effect_mode     <= csr_data[0];
            lsaf_pkg::CSR_FLICKER_PERIOD:  cfg_ff.flicker_period  <= csr_data;
            lsaf_pkg::CSR_RED_GAIN:        cfg_ff.red_gain        <= csr_data[9:0];
            lsaf_pkg::CSR_GREEN_GAIN:      cfg_ff.green_gain      <= csr_data[9:0];
            lsaf_pkg::CSR_BLUE_GAIN:       cfg_ff.blue_gain       <= csr_data[9:0];
            lsaf_pkg::CSR_BRIGHTNESS_GAIN: cfg_ff.brightness_gain <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   lsaf_phase u_phase (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .period_wr (period_wr),
      .cfg       (cfg_ff),
      .blank     (blank),
      .busy      (phase_busy)
   );

   lsaf_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .blank     (blank),
      .col       (col),
      .col_valid (col_valid),
      .busy      (scale_busy)
   );

   lsaf_store u_store (
      .clock     (clock),
      .reset     (reset),
      .start     (col_valid),
      .col       (col),
      .mode      (cfg_ff.animation_mode),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .busy      (store_busy)
   );

endmodule

// ===== rtl/lsaf_checker.sv =====
// Port-level checks for the LED strip animation frame top level, with its bind.
`timescale 1ns / 1ps

module lsaf_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input lsaf_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again right after an item");

   a_last_marks_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.frame_last ==
         (rsp_data.led_index == lsaf_pkg::LED_INDEX_W'(lsaf_pkg::FRAME_LEDS - 1))))
      else $error("frame_last does not match final LED");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

endmodule

bind led_strip_animation_frame_top lsaf_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== dv/lsaf_frame_checker.sv =====
// Checker that predicts every LED frame item of the animation block and compares it on arrival.
`timescale 1ns / 1ps

module lsaf_frame_checker
   import lsaf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_type                req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_type                rsp_data,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic [31:0]            mismatch_count,
   output logic [31:0]            leds_outstanding
);

   localparam int REPORT_LIMIT = 10;

   cfg_type           shadow_cfg;
   colour_type        frame_shadow [FRAME_LEDS];
   logic [ADDR_W-1:0] ring_ptr;
   logic [TICK_W-1:0] tick_count;
   rsp_type           expected_leds [$];
   int unsigned       fail_total = 0;

   function automatic logic [CHAN_W-1:0] scale_channel(input logic [CHAN_W-1:0] base,
                                                       input logic [GAIN_W-1:0] gain,
                                                       input logic [GAIN_W-1:0] bright);
      logic [28:0] product;
      product = 29'(base) * 29'(gain) * 29'(bright) + 29'd32768;
      if (product[28:16] > 13'd255) begin
         return 8'hFF;
      end
      return product[23:16];
   endfunction

   task automatic clear_shadow();
      shadow_cfg.animation_mode  = MODE_GLOW;
      shadow_cfg.effect_mode     = 1'b1;
      shadow_cfg.flicker_period  = 16'd1;
      shadow_cfg.red_gain        = GAIN_UNITY;
      shadow_cfg.green_gain      = GAIN_UNITY;
      shadow_cfg.blue_gain       = GAIN_UNITY;
      shadow_cfg.brightness_gain = GAIN_UNITY;
      for (int i = 0; i < FRAME_LEDS; i++) begin
         frame_shadow[i] = '0;
      end
      ring_ptr   = '0;
      tick_count = '0;
      expected_leds.delete();
   endtask

   task automatic write_shadow_reg(input logic [CSR_INDEX_W-1:0] index,
                                   input logic [CSR_DATA_W-1:0] value);
      case (index)
         CSR_ANIMATION_MODE:  shadow_cfg.animation_mode  = value[1:0];
         CSR_EFFECT_MODE:     shadow_cfg.effect_mode     = value[0];
         CSR_FLICKER_PERIOD:  shadow_cfg.flicker_period  = value[PERIOD_W-1:0];
         CSR_RED_GAIN:        shadow_cfg.red_gain        = value[GAIN_W-1:0];
         CSR_GREEN_GAIN:      shadow_cfg.green_gain      = value[GAIN_W-1:0];
         CSR_BLUE_GAIN:       shadow_cfg.blue_gain       = value[GAIN_W-1:0];
         CSR_BRIGHTNESS_GAIN: shadow_cfg.brightness_gain = value[GAIN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic predict_tick(input req_type item);
      colour_type        col;
      rsp_type           led;
      logic [TICK_W-1:0] period_ext;
      tick_count = tick_count + TICK_W'(1);
      col.red   = scale_channel(item.base_red, shadow_cfg.red_gain, shadow_cfg.brightness_gain);
      col.green = scale_channel(item.base_green, shadow_cfg.green_gain,
                                shadow_cfg.brightness_gain);
      col.blue  = scale_channel(item.base_blue, shadow_cfg.blue_gain,
                                shadow_cfg.brightness_gain);
      period_ext = TICK_W'(shadow_cfg.flicker_period);
      if (shadow_cfg.effect_mode && period_ext != '0 &&
          (tick_count % period_ext) < (period_ext >> 1)) begin
         col = '0;
      end
      case (shadow_cfg.animation_mode)
         MODE_ROTATE: begin
            frame_shadow[ring_ptr] = col;
            ring_ptr = ring_ptr - ADDR_W'(1);
         end
         MODE_SHIFT: begin
            for (int i = 0; i < FRAME_LEDS - 1; i++) begin
               frame_shadow[i] = frame_shadow[i + 1];
            end
            frame_shadow[FRAME_LEDS - 1] = col;
         end
         MODE_GLOW: begin
            for (int i = 0; i < FRAME_LEDS; i++) begin
               frame_shadow[i] = col;
            end
         end
         default: ;
      endcase
      for (int k = 0; k < FRAME_LEDS; k++) begin
         led.led_index  = LED_INDEX_W'(k);
         led.led_red    = frame_shadow[k].red;
         led.led_green  = frame_shadow[k].green;
         led.led_blue   = frame_shadow[k].blue;
         led.frame_last = (k == FRAME_LEDS - 1);
         expected_leds.push_back(led);
      end
   endtask

   task automatic check_led(input rsp_type actual);
      rsp_type want;
      if (expected_leds.size() == 0) begin
         fail_total++;
         if (fail_total <= REPORT_LIMIT) begin
            $display("unexpected LED item: idx %0d rgb %02h_%02h_%02h last %0b",
                     actual.led_index, actual.led_red, actual.led_green, actual.led_blue,
                     actual.frame_last);
         end
         return;
      end
      want = expected_leds.pop_front();
      if (actual.led_index !== want.led_index || actual.led_red !== want.led_red ||
          actual.led_green !== want.led_green || actual.led_blue !== want.led_blue ||
          actual.frame_last !== want.frame_last) begin
         fail_total++;
         if (fail_total <= REPORT_LIMIT) begin
            $display("LED mismatch at %0t: expected idx %0d rgb %02h_%02h_%02h last %0b",
                     $realtime, want.led_index, want.led_red, want.led_green, want.led_blue,
                     want.frame_last);
            $display("                  got      idx %0d rgb %02h_%02h_%02h last %0b",
                     actual.led_index, actual.led_red, actual.led_green, actual.led_blue,
                     actual.frame_last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_shadow();
      end else begin
         if (csr_valid && csr_ready) begin
            write_shadow_reg(csr_index, csr_data);
         end
         if (rsp_valid && !rsp_stall) begin
            check_led(rsp_data);
         end
         if (req_valid && !req_stall) begin
            predict_tick(req_data);
         end
      end
      mismatch_count   <= fail_total;
      leds_outstanding <= expected_leds.size();
   end

endmodule

// ===== dv/led_strip_animation_frame_top_tb.sv =====
// Testbench top: drives colours and register writes into the LED animation block, gives the verdict.
`timescale 1ns / 1ps

module led_strip_animation_frame_top_tb;
   import lsaf_pkg::*;

   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int LATENCY_TAIL    = 80;
   localparam int RSP_HOLD_CYCLES = 500;
   localparam int RANDOM_ITEMS    = 430;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;
   logic [31:0]            mismatch_count;
   logic [31:0]            leds_outstanding;

   int unsigned rsp_hold_cycles = 0;
   bit          sender_idles    = 1'b1;
   bit          receiver_idles  = 1'b1;

   led_strip_animation_frame_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   lsaf_frame_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatch_count   (mismatch_count),
      .leds_outstanding (leds_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("led_strip_animation_frame_top_tb: FAIL");
      $finish;
   end

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles != 0) begin
            rsp_stall <= 1'b1;
            rsp_hold_cycles--;
         end else begin
            rsp_stall <= receiver_idles && ($urandom_range(99) < 18);
         end
      end
   end

   task automatic send_item(input req_type item);
      if (sender_idles && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 90)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic finish_phase();
      req_valid <= 1'b0;
      @(posedge clock);
      while (leds_outstanding != 0) @(posedge clock);
      repeat (LATENCY_TAIL) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_all(input logic [CSR_DATA_W-1:0] mode, input logic [CSR_DATA_W-1:0] effect,
                          input logic [CSR_DATA_W-1:0] period, input logic [CSR_DATA_W-1:0] red,
                          input logic [CSR_DATA_W-1:0] green, input logic [CSR_DATA_W-1:0] blue,
                          input logic [CSR_DATA_W-1:0] bright);
      write_reg(CSR_ANIMATION_MODE, mode);
      write_reg(CSR_EFFECT_MODE, effect);
      write_reg(CSR_FLICKER_PERIOD, period);
      write_reg(CSR_RED_GAIN, red);
      write_reg(CSR_GREEN_GAIN, green);
      write_reg(CSR_BLUE_GAIN, blue);
      write_reg(CSR_BRIGHTNESS_GAIN, bright);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_gain();
      case ($urandom_range(7))
         0:       return '0;
         1:       return 16'd1023;
         2:       return 16'(GAIN_UNITY);
         3:       return 16'($urandom);
         default: return 16'($urandom_range(128, 400));
      endcase
   endfunction

   initial begin
      req_type                item;
      logic [CSR_DATA_W-1:0] period;
      int unsigned           items_sent;
      int unsigned           phase_items;
      int unsigned           phase;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_ANIMATION_MODE;
      csr_data  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: glow fill, flicker on with a period that never blanks
      send_item(req_type'{8'h00, 8'h00, 8'h00});
      send_item(req_type'{8'hFF, 8'hFF, 8'hFF});
      send_item(req_type'{8'h80, 8'h7F, 8'h01});
      finish_phase();

      // clamp at full gain, zero gain, tiny gain
      set_all(16'(MODE_GLOW), 0, 0, 16'd1023, 16'd0, 16'd1, 16'd1023);
      send_item(req_type'{8'hFF, 8'hFF, 8'hFF});
      send_item(req_type'{8'h01, 8'h80, 8'hFF});
      finish_phase();

      // round half up across the ring wrap
      set_all(16'(MODE_ROTATE), 0, 0, 16'd1, 16'd1, 16'd2, 16'd256);
      send_item(req_type'{8'h80, 8'h7F, 8'h80});
      send_item(req_type'{8'hFF, 8'hFF, 8'hFF});
      send_item(req_type'{8'h81, 8'h01, 8'h7F});
      finish_phase();

      // wide data masked to shift mode, ignored index, flicker period 4
      write_reg(CSR_UNUSED, 16'hFFFF);
      set_all(16'hFFF6, 16'hFFFF, 16'd4, 16'hFD00, 16'd256, 16'd256, 16'd256);
      repeat (5) send_item(req_type'($urandom));
      finish_phase();

      // frame held, largest period, zero brightness
      set_all(16'(MODE_NONE), 1, 16'hFFFF, 16'd1023, 16'd1023, 16'd1023, 16'd0);
      repeat (3) send_item(req_type'($urandom));
      finish_phase();

      // odd period blanks one tick in three
      set_all(16'(MODE_ROTATE), 1, 16'd3, 16'd300, 16'd200, 16'd100, 16'd512);
      repeat (4) send_item(req_type'($urandom));
      finish_phase();

      items_sent = 0;
      phase      = 0;
      while (items_sent < RANDOM_ITEMS) begin
         case ($urandom_range(5))
            0:       period = '0;
            1:       period = 16'd1;
            2:       period = 16'($urandom_range(2, 8));
            3:       period = 16'($urandom_range(9, 64));
            4:       period = 16'hFFFF;
            default: period = 16'($urandom);
         endcase
         if ($urandom_range(2) == 0) begin
            write_reg(CSR_UNUSED, 16'($urandom));
         end
         set_all(16'($urandom_range(3)), 16'($urandom_range(1)), period, pick_gain(),
                 pick_gain(), pick_gain(),
                 $urandom_range(3) == 0 ? pick_gain() : 16'(GAIN_UNITY));
         phase_items = $urandom_range(15, 45);
         if (phase == 2) begin
            rsp_hold_cycles = RSP_HOLD_CYCLES;
            phase_items     = 30;
         end
         if (phase == 4) begin
            sender_idles   = 1'b0;
            receiver_idles = 1'b0;
         end
         repeat (phase_items) begin
            item = req_type'($urandom);
            if ($urandom_range(9) == 0) begin
               item = $urandom_range(1) ? '1 : '0;
            end
            send_item(item);
            items_sent++;
            if ($urandom_range(99) == 0) begin
               finish_phase();
            end
         end
         finish_phase();
         sender_idles   = 1'b1;
         receiver_idles = 1'b1;
         phase++;
      end

      if (mismatch_count == 0 && leds_outstanding == 0) begin
         $display("led_strip_animation_frame_top_tb: PASS");
      end else begin
         $display("led_strip_animation_frame_top_tb: FAIL");
      end
      $finish;
   end

endmodule

// ===== led_strip_animation_frame_top.f =====
rtl/lsaf_pkg.sv
rtl/lsaf_scale.sv
rtl/lsaf_phase.sv
rtl/lsaf_store.sv
rtl/led_strip_animation_frame_top.sv
rtl/lsaf_checker.sv
dv/lsaf_frame_checker.sv
dv/led_strip_animation_frame_top_tb.sv
